### src/fzp_pkg.sv
// shared types, constants and rule tables for the fuzzy tuned pi controller
package fzp_pkg;

    localparam int FZ_SETS = 7;

    // configuration register indexes
    localparam logic [2:0] CFG_INIT_P   = 3'd0;
    localparam logic [2:0] CFG_INIT_I   = 3'd1;
    localparam logic [2:0] CFG_ERR_BAND = 3'd2;
    localparam logic [2:0] CFG_OS_BAND  = 3'd3;
    localparam logic [2:0] CFG_PWM_LIM  = 3'd4;

    localparam logic [23:0] INIT_P_RST = 24'd543949;
    localparam logic [23:0] INIT_I_RST = 24'd78643;
    localparam logic [9:0]  BAND_RST   = 10'd60;
    localparam logic [9:0]  OS_RST     = 10'd8;
    localparam logic [15:0] LIMIT_RST  = 16'd7200;

    localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
    localparam logic [31:0] RECIP_50   = 32'd1342178;     // ceil(2^26 / 50)
    localparam logic [31:0] RECIP_10   = 32'd858993460;   // ceil(2^33 / 10)
    localparam logic signed [43:0] STEP_LIMIT = 44'sd32768000;
    localparam logic signed [31:0] PULL_DOWN  = -32'sd5898240;   // -360 in q16.14

    // fuzzy set corners on the scaled axis, NB..PB
    localparam logic [1:0] SH_LEFT  = 2'd0;
    localparam logic [1:0] SH_TRI   = 2'd1;
    localparam logic [1:0] SH_RIGHT = 2'd2;
    localparam logic [1:0] FZ_SHAPE [FZ_SETS] =
        '{SH_LEFT, SH_TRI, SH_TRI, SH_TRI, SH_TRI, SH_TRI, SH_RIGHT};
    localparam logic signed [3:0] FZ_A [FZ_SETS] =
        '{-4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1};
    localparam logic signed [3:0] FZ_B [FZ_SETS] =
        '{-4'sd1, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};
    localparam logic signed [3:0] FZ_C [FZ_SETS] =
        '{4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd0};

    // rule labels, row-major over (error set, change set)
    localparam logic [2:0] RULE_P [FZ_SETS*FZ_SETS] = '{
        3'd6,3'd6,3'd5,3'd5,3'd4,3'd3,3'd3, 3'd6,3'd6,3'd5,3'd4,3'd4,3'd3,3'd3,
        3'd5,3'd5,3'd5,3'd4,3'd3,3'd2,3'd2, 3'd5,3'd5,3'd4,3'd3,3'd2,3'd1,3'd1,
        3'd4,3'd4,3'd3,3'd2,3'd2,3'd1,3'd1, 3'd4,3'd3,3'd2,3'd1,3'd1,3'd1,3'd0,
        3'd3,3'd3,3'd1,3'd1,3'd1,3'd0,3'd0};
    localparam logic [2:0] RULE_I [FZ_SETS*FZ_SETS] = '{
        3'd0,3'd0,3'd1,3'd1,3'd2,3'd3,3'd3, 3'd0,3'd0,3'd1,3'd2,3'd2,3'd3,3'd3,
        3'd0,3'd1,3'd2,3'd2,3'd3,3'd4,3'd4, 3'd1,3'd1,3'd2,3'd3,3'd4,3'd5,3'd5,
        3'd1,3'd2,3'd3,3'd4,3'd4,3'd5,3'd6, 3'd3,3'd3,3'd4,3'd4,3'd5,3'd6,3'd6,
        3'd3,3'd3,3'd4,3'd5,3'd5,3'd6,3'd6};

    // gain change base (already times 32768) and slope per label
    localparam logic signed [20:0] DP_BASE [FZ_SETS] = '{-21'sd327680, -21'sd491520,
        -21'sd327680, 21'sd0, 21'sd327680, 21'sd491520, 21'sd327680};
    localparam logic signed [5:0] DP_SLOPE [FZ_SETS] =
        '{-6'sd20, -6'sd5, 6'sd0, 6'sd0, 6'sd0, 6'sd5, 6'sd20};
    localparam logic signed [20:0] DI_BASE [FZ_SETS] = '{-21'sd65536, -21'sd98304,
        -21'sd65536, 21'sd0, 21'sd65536, 21'sd98304, 21'sd65536};
    localparam logic signed [5:0] DI_SLOPE [FZ_SETS] =
        '{-6'sd4, -6'sd1, 6'sd0, 6'sd0, 6'sd0, 6'sd1, 6'sd4};

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FUZZ, S_MULP, S_MULI, S_GAIN,
        S_MULA, S_MULB, S_MULC, S_MULD, S_FIN, S_DONE
    } t_state;

    typedef enum logic [1:0] {FZ_IDLE, FZ_GRADE, FZ_PICK, FZ_DONE} t_fz_state;

    typedef struct packed {
        logic               start;
        logic signed [16:0] err;
        logic signed [16:0] err_last;
    } t_fz_ctl;

    typedef struct packed {
        logic        done;
        logic [2:0]  lp;
        logic [2:0]  li;
        logic [15:0] lsd;
    } t_fz_stat;

endpackage

### src/fzp_mul.sv
// shared unsigned multiplier with registered product
module fzp_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

### src/fzp_fuzzy.sv
// fuzzifier and first-maximum rule pick, one fuzzy set per cycle
module fzp_fuzzy (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fzp_pkg::t_fz_ctl i_ctl,
    output fzp_pkg::t_fz_stat o_stat
);
    import fzp_pkg::*;

    t_fz_state   r_state, n_state;
    logic [2:0]  r_idx;
    logic [15:0] r_ge [FZ_SETS];
    logic [15:0] r_gc [FZ_SETS];
    logic [15:0] r_max_e, r_max_c;
    logic [2:0]  r_bi, r_bj;
    logic        r_fnd_e, r_fnd_c;
    logic signed [17:0] diff;
    logic signed [20:0] num_e, num_c;
    logic [15:0] g_e, g_c, lsd;
    logic [5:0]  rule_sel;

    // floor(x * 16384 / 5) >> sh for x up to 40
    function automatic logic [15:0] frac(input logic [5:0] x, input logic [1:0] sh);
        logic [9:0]  t;
        logic [3:0]  q;
        logic [5:0]  r;
        logic [13:0] rf;
        logic [17:0] f;
        t = 10'(x) * 10'd13;
        q = t[9:6];
        r = x - 6'(5 * q);
        case (r[2:0])
            3'd1: rf = 14'd3276;
            3'd2: rf = 14'd6553;
            3'd3: rf = 14'd9830;
            3'd4: rf = 14'd13107;
            default: rf = 14'd0;
        endcase
        f = {q, 14'b0} + 18'(rf);
        f = f >> sh;
        return f[15:0];
    endfunction

    // q1.15 membership of num / unit in set idx
    function automatic logic [15:0] grade(input logic signed [20:0] num,
                                          input logic [2:0] idx, input logic ax);
        logic signed [20:0] u, pa, pb, pc, dd;
        logic [5:0]  x;
        logic [1:0]  sh;
        logic [15:0] g;
        u  = ax ? 21'sd10 : 21'sd20;
        pa = 21'(FZ_A[idx]) * u;
        pb = 21'(FZ_B[idx]) * u;
        pc = 21'(FZ_C[idx]) * u;
        x  = 6'd0;
        dd = pb - pa;
        g  = 16'd0;
        case (FZ_SHAPE[idx])
            SH_LEFT: begin
                if (num <= pa) g = 16'd32768;
                else if (num <= pb) x = 6'(pb - num);
            end
            SH_RIGHT: begin
                if (num >= pb) g = 16'd32768;
                else if (num > pa) x = 6'(num - pa);
            end
            default: begin
                if (num > pa && num <= pb) x = 6'(num - pa);
                else if (num > pb && num <= pc) begin
                    x  = 6'(pc - num);
                    dd = pc - pb;
                end
            end
        endcase
        sh = (dd == 21'sd10) ? 2'd0 : (dd == 21'sd20) ? 2'd1 : 2'd2;
        if (g == 16'd0) g = frac(x, sh);
        return g;
    endfunction

    // scaled inputs: e over unit 20 and ec*3 over unit 10
    assign diff     = 18'(i_ctl.err) - 18'(i_ctl.err_last);
    assign num_e    = 21'(i_ctl.err);
    assign num_c    = 21'(diff) * 21'sd3;
    assign g_e      = grade(num_e, r_idx, 1'b0);
    assign g_c      = grade(num_c, r_idx, 1'b1);
    assign lsd      = (r_max_e < r_max_c) ? r_max_e : r_max_c;
    assign rule_sel = 6'(r_bi * 7) + 6'(r_bj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= FZ_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FZ_IDLE:  if (i_ctl.start) n_state = FZ_GRADE;
            FZ_GRADE: if (r_idx == 3'd6) n_state = FZ_PICK;
            FZ_PICK:  if (r_idx == 3'd6) n_state = FZ_DONE;
            FZ_DONE:  n_state = FZ_IDLE;
            default:  n_state = FZ_IDLE;
        endcase
        o_stat.done = (r_state == FZ_DONE);
        o_stat.lp   = RULE_P[rule_sel];
        o_stat.li   = RULE_I[rule_sel];
        o_stat.lsd  = lsd;
    end

    // grading pass then first-maximum search
    always_ff @(posedge i_clk) begin
        case (r_state)
            FZ_IDLE: begin
                r_idx   <= 3'd0;
                r_max_e <= 16'd0;
                r_max_c <= 16'd0;
                r_bi    <= 3'd0;
                r_bj    <= 3'd0;
                r_fnd_e <= 1'b0;
                r_fnd_c <= 1'b0;
            end
            FZ_GRADE: begin
                r_ge[r_idx] <= g_e;
                r_gc[r_idx] <= g_c;
                if (g_e > r_max_e) r_max_e <= g_e;
                if (g_c > r_max_c) r_max_c <= g_c;
                r_idx <= (r_idx == 3'd6) ? 3'd0 : r_idx + 3'd1;
            end
            FZ_PICK: begin
                if (!r_fnd_e && r_ge[r_idx] >= lsd) begin
                    r_fnd_e <= 1'b1;
                    r_bi    <= r_idx;
                end
                if (!r_fnd_c && r_gc[r_idx] >= lsd) begin
                    r_fnd_c <= 1'b1;
                    r_bj    <= r_idx;
                end
                r_idx <= r_idx + 3'd1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == FZ_DONE |-> r_fnd_e && r_fnd_c)
        else $error("rule cell not found");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == FZ_PICK |-> r_max_e <= 16'd32768 && r_max_c <= 16'd32768)
        else $error("membership above one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == FZ_IDLE)
        else $error("start while busy");
endmodule

### src/fuzzy_tuned_incremental_pid.sv
// top level: sequencer, gain tuning, incremental pi step and pwm level
// When the error is inside error_band an item goes through the accept step,
// one range check, the fuzzifier (grading the seven fuzzy sets, searching for
// the winning rule cell, handing it over) and then the gain update, the step
// products and the level update, with five products through the one shared
// multiplier. Outside the band the fuzzifier and the gain update are skipped
// and an item uses three products. Input stall goes high after the accept and
// stays high until the sequencer is back in idle, including any wait for a
// stalled result to leave. The result is then held in an output register, so
// a further item can be taken while it waits.
// Writes to initial_p_gain or initial_i_gain also load the running gains.
module fuzzy_tuned_incremental_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_setpoint,
    input  logic [15:0] i_measured,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pwm_duty,
    output logic [23:0] o_p_gain_now,
    output logic [23:0] o_i_gain_now,
    output logic        o_overshoot_armed,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import fzp_pkg::*;

    t_state r_state, n_state;
    logic [23:0] r_init_p, r_init_i, r_p, r_i;
    logic [9:0]  r_band, r_ob;
    logic [15:0] r_limit;
    logic signed [16:0] r_e, r_last;
    logic [29:0] r_level;
    logic        r_armed;
    logic signed [20:0] r_yp, r_yi;
    logic signed [16:0] r_dp;
    logic [40:0] r_s1;
    logic        r_nneg;
    logic [28:0] r_nmag;
    logic        r_ovalid, r_oarm;
    logic [15:0] r_oduty;
    logic [23:0] r_op, r_oi;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    t_fz_ctl  fz_ctl;
    t_fz_stat fz_st;
    logic        accept, in_band, out_free;
    logic signed [17:0] e18, band18, ob18;
    logic [20:0] mag_p, mag_i;
    logic [15:0] abs_e, abs_le;
    logic signed [20:0] yp, yi;
    logic signed [16:0] dq, di;
    logic signed [25:0] vp, vi;
    logic signed [43:0] t1, t2, n, nc;
    logic [28:0] nmag;
    logic signed [31:0] inc, lv;
    logic [29:0] top;

    fzp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_prod(prod));
    fzp_fuzzy u_fuzzy (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(fz_ctl), .o_stat(fz_st));

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign e18      = 18'(r_e);
    assign band18   = 18'(r_band);
    assign ob18     = 18'(r_ob);
    assign in_band  = (e18 <= band18) && (e18 >= -band18);
    assign abs_e    = r_e[16] ? 16'(-r_e) : r_e[15:0];
    assign abs_le   = r_last[16] ? 16'(-r_last) : r_last[15:0];
    assign mag_p    = (r_yp[20] ? 21'(-r_yp) : 21'(r_yp)) + 21'd25;
    assign mag_i    = (r_yi[20] ? 21'(-r_yi) : 21'(r_yi)) + 21'd25;
    assign top      = {r_limit, 14'b0};

    assign fz_ctl.start    = (r_state == S_CHECK) && in_band;
    assign fz_ctl.err      = r_e;
    assign fz_ctl.err_last = r_last;

    // rule values for the chosen labels
    assign yp = DP_BASE[fz_st.lp] + DP_SLOPE[fz_st.lp] * $signed({5'b0, fz_st.lsd});
    assign yi = DI_BASE[fz_st.li] + DI_SLOPE[fz_st.li] * $signed({5'b0, fz_st.lsd});

    // rounded gain changes from the reciprocal products
    assign dq = r_yp[20] ? -$signed({1'b0, prod[41:26]}) : $signed({1'b0, prod[41:26]});
    assign di = r_yi[20] ? -$signed({1'b0, prod[41:26]}) : $signed({1'b0, prod[41:26]});
    assign vp = $signed({2'b0, r_p}) + 26'(r_dp);
    assign vi = $signed({2'b0, r_i}) + 26'(di);

    // step numerator, clamp and scale by 9
    assign t1 = r_e[16] ? -$signed({3'b0, r_s1}) : $signed({3'b0, r_s1});
    assign t2 = r_last[16] ? -$signed({3'b0, prod[40:0]}) : $signed({3'b0, prod[40:0]});
    assign n  = t1 - t2;
    assign nc = (n > STEP_LIMIT) ? STEP_LIMIT : (n < -STEP_LIMIT) ? -STEP_LIMIT : n;
    assign nmag = 29'(nc[43] ? -nc : nc) * 29'd9 + 29'd5;

    // shared multiplier operands
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_MULP: begin mul_a = 32'(mag_p); mul_b = RECIP_50; end
            S_MULI: begin mul_a = 32'(mag_i); mul_b = RECIP_50; end
            S_MULA: begin mul_a = 32'({1'b0, r_p} + {1'b0, r_i}); mul_b = 32'(abs_e); end
            S_MULB: begin mul_a = 32'(r_p); mul_b = 32'(abs_le); end
            S_MULD: begin mul_a = 32'(r_nmag); mul_b = RECIP_10; end
            default: ;
        endcase
    end

    // pwm level update for the case at hand
    always_comb begin
        inc = r_nneg ? -32'(prod[57:33]) : 32'(prod[57:33]);
        lv  = $signed({2'b0, r_level});
        if (e18 > band18) begin
            lv  = $signed({2'b0, top});
            inc = 32'sd0;
        end else if (e18 < -band18) begin
            lv  = 32'sd0;
            inc = 32'sd0;
        end else if (e18 < ob18 && r_armed) begin
            lv  = 32'sd0;
            inc = 32'sd0;
        end else if (-e18 > ob18) begin
            inc = PULL_DOWN;
        end
        lv = lv + inc;
        if (lv > $signed({2'b0, top})) lv = $signed({2'b0, top});
        if (lv < 32'sd0) lv = 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CHECK;
            S_CHECK: n_state = in_band ? S_FUZZ : S_MULA;
            S_FUZZ:  if (fz_st.done) n_state = S_MULP;
            S_MULP:  n_state = S_MULI;
            S_MULI:  n_state = S_GAIN;
            S_GAIN:  n_state = S_MULA;
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_MULC;
            S_MULC:  n_state = S_MULD;
            S_MULD:  n_state = S_FIN;
            S_FIN:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // controller state, configuration and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_p <= INIT_P_RST;
            r_init_i <= INIT_I_RST;
            r_p      <= INIT_P_RST;
            r_i      <= INIT_I_RST;
            r_band   <= BAND_RST;
            r_ob     <= OS_RST;
            r_limit  <= LIMIT_RST;
            r_last   <= 17'sd0;
            r_level  <= 30'd0;
            r_armed  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_P:   begin r_init_p <= i_cfg_data; r_p <= i_cfg_data; end
                    CFG_INIT_I:   begin r_init_i <= i_cfg_data; r_i <= i_cfg_data; end
                    CFG_ERR_BAND: r_band  <= i_cfg_data[9:0];
                    CFG_OS_BAND:  r_ob    <= i_cfg_data[9:0];
                    CFG_PWM_LIM:  r_limit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_GAIN: begin
                    r_p <= (vp < 26'sd0) ? 24'd0 :
                           (vp > $signed({2'b0, GAIN_MAX})) ? GAIN_MAX : vp[23:0];
                    r_i <= (vi < 26'sd0) ? 24'd0 :
                           (vi > $signed({2'b0, GAIN_MAX})) ? GAIN_MAX : vi[23:0];
                end
                S_FIN: begin
                    r_level <= lv[29:0];
                    r_last  <= r_e;
                    if (e18 > band18) r_armed <= 1'b1;
                    else if (e18 >= -band18 && e18 < ob18) r_armed <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_e <= $signed({1'b0, i_setpoint}) - $signed({1'b0, i_measured});
            S_FUZZ: begin
                r_yp <= yp;
                r_yi <= yi;
            end
            S_MULI: r_dp <= dq;
            S_MULB: r_s1 <= prod[40:0];
            S_MULC: begin
                r_nneg <= nc[43];
                r_nmag <= nmag;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                r_oduty  <= r_level[29:14];
                r_op     <= r_p;
                r_oi     <= r_i;
                r_oarm   <= r_armed;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_pwm_duty        = r_oduty;
    assign o_p_gain_now      = r_op;
    assign o_i_gain_now      = r_oi;
    assign o_overshoot_armed = r_oarm;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> r_state == S_DONE)
        else $error("finish step not followed by done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fz_st.done |-> r_state == S_FUZZ)
        else $error("fuzzy result outside tuning step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_level <= top)
        else $error("pwm level above limit");
endmodule
